// ===== rtl/core/npp_pkg.sv =====
// Shared types and constants for the next-pc predictor with register file.
package npp_pkg;

    // Command codes
    localparam logic [1:0] CMD_PEEK = 2'd0;
    localparam logic [1:0] CMD_POKE = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    // Register file layout
    localparam int unsigned NUM_REGS = 13;
    localparam int unsigned REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_CCR = 4'd8;
    localparam logic [REG_IDX_W-1:0] REG_PC = 4'd9;

    // Condition code bits within ccr
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_V = 1;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_N = 3;

    // Absolute targets taken from memory or the instruction are 24-bit addresses
    localparam logic [31:0] ADDR_MASK = 32'h00ff_ffff;

    // Register file context handed to the predictor
    typedef struct packed {
        logic [31:0] pc;
        logic [3:0]  flags;
        logic [31:0] sel_reg;
    } npp_ctx_t;

endpackage

// ===== rtl/core/npp_predict.sv =====
// Combinational next-instruction-address decode from opcode bytes and register context.
module npp_predict
    import npp_pkg::*;
(
    input  npp_ctx_t    ctx,
    input  logic [31:0] instr_bytes,
    input  logic [31:0] memory_word,
    output logic [31:0] dest
);

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [3:0]  hi;
    logic [31:0] disp8;
    logic [31:0] disp16;
    logic [31:0] offset;
    logic [31:0] abs_val;
    logic        use_abs;

    // Branch condition test against ccr flags
    function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
        logic c;
        logic v;
        logic z;
        logic n;
        logic res;
        c = f[FLAG_C];
        v = f[FLAG_V];
        z = f[FLAG_Z];
        n = f[FLAG_N];
        case (cond)
            4'h0: res = 1'b1;
            4'h1: res = 1'b0;
            4'h2: res = !(c || z);
            4'h3: res = c || z;
            4'h4: res = !c;
            4'h5: res = c;
            4'h6: res = !z;
            4'h7: res = z;
            4'h8: res = !v;
            4'h9: res = v;
            4'ha: res = !n;
            4'hb: res = n;
            4'hc: res = (n == v);
            4'hd: res = (n != v);
            4'he: res = !z && (n == v);
            default: res = z || (n != v);
        endcase
        return res;
    endfunction

    assign b0 = instr_bytes[31:24];
    assign b1 = instr_bytes[23:16];
    assign b2 = instr_bytes[15:8];
    assign b3 = instr_bytes[7:0];
    assign hi = b1[7:4];

    // Signed displacements, already including the instruction length
    assign disp8  = {{24{b1[7]}}, b1} + 32'd2;
    assign disp16 = {{16{instr_bytes[15]}}, instr_bytes[15:0]} + 32'd4;

    // Opcode decode: either a pc-relative offset or an absolute target
    always_comb
    begin
        use_abs = 1'b0;
        abs_val = '0;
        offset  = 32'd2;
        case (b0) inside
            8'h01:
            begin
                if (hi == 4'h0 || hi == 4'h4)
                begin
                    case (b2)
                        8'h6b: offset = b3[1] ? 32'd8 : 32'd6;
                        8'h6f: offset = 32'd6;
                        8'h78: offset = 32'd10;
                        default: offset = 32'd4;
                    endcase
                end
                else if (hi == 4'h8 || hi == 4'ha)
                begin
                    offset = 32'd2;
                end
                else
                begin
                    offset = 32'd4;
                end
            end
            [8'h00:8'h3f]: offset = 32'd2;
            [8'h40:8'h4f]: offset = cond_holds(b0[3:0], ctx.flags) ? disp8 : 32'd2;
            8'h54, 8'h56, 8'h5b, 8'h5f:
            begin
                use_abs = 1'b1;
                abs_val = memory_word & ADDR_MASK;
            end
            8'h55: offset = disp8;
            8'h58: offset = cond_holds(hi, ctx.flags) ? disp16 : 32'd4;
            8'h59, 8'h5d:
            begin
                use_abs = 1'b1;
                abs_val = ctx.sel_reg;
            end
            8'h5a, 8'h5e:
            begin
                use_abs = 1'b1;
                abs_val = instr_bytes & ADDR_MASK;
            end
            8'h5c: offset = disp16;
            8'h6a, 8'h6b:
            begin
                if (hi == 4'h1 || hi == 4'h2 || hi == 4'ha)
                begin
                    offset = 32'd6;
                end
                else if (hi == 4'h3)
                begin
                    offset = 32'd8;
                end
                else
                begin
                    offset = 32'd4;
                end
            end
            8'h6e, 8'h6f: offset = 32'd4;
            8'h78: offset = 32'd8;
            8'h7a: offset = 32'd6;
            8'h79, [8'h7b:8'h7f]: offset = 32'd4;
            default: offset = 32'd2;
        endcase
    end

    assign dest = use_abs ? abs_val : (ctx.pc + offset);

endmodule

// ===== rtl/core/next_pc_predictor_with_register_file_unit.sv =====
// Top level: register file with peek, poke and next-pc prediction, input and result registers.
// Each item passes an input register, then register file access and opcode decode,
// then the result register. A new item is taken every cycle while the result side
// keeps up. A result stall holds the result register first, then backs up into the
// input register and stalls the input. A poke is written as its item enters the
// result register, so the very next item sees it. All thirteen registers read as
// zero after reset.
module next_pc_predictor_with_register_file_unit
    import npp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  reg_id,
    input  logic [31:0] write_value,
    input  logic [31:0] instr_bytes,
    input  logic [31:0] memory_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_value,
    output logic        id_valid,
    output logic [31:0] step_dest
);

    // Input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_cmd_reg;
    logic [3:0]  s1_id_reg;
    logic [31:0] s1_wv_reg;
    logic [31:0] s1_ib_reg;
    logic [31:0] s1_mem_reg;

    // Register file
    logic [31:0] rf_reg [NUM_REGS];

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] read_value_reg;
    logic [31:0] read_value_next;
    logic        id_valid_reg;
    logic        id_valid_next;
    logic [31:0] step_dest_reg;
    logic [31:0] step_dest_next;

    logic                 advance;
    logic                 in_xfer;
    logic                 id_ok;
    logic [REG_IDX_W-1:0] rd_idx;
    logic [31:0]          rd_data;
    logic                 rf_we;
    npp_ctx_t             ctx;
    logic [31:0]          pred_dest;

    // Flow control: result register frees up when empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg <= cmd;
            s1_id_reg  <= reg_id;
            s1_wv_reg  <= write_value;
            s1_ib_reg  <= instr_bytes;
            s1_mem_reg <= memory_word;
        end
    end

    // Register file read: peek id, or the jump register selector on step
    assign id_ok  = (s1_id_reg < REG_IDX_W'(NUM_REGS));
    assign rd_idx = (s1_cmd_reg == CMD_STEP) ? {1'b0, s1_ib_reg[22:20]} : s1_id_reg;
    assign rd_data = (rd_idx < REG_IDX_W'(NUM_REGS)) ? rf_reg[rd_idx] : '0;

    // Predictor context
    assign ctx.pc      = rf_reg[REG_PC];
    assign ctx.flags   = rf_reg[REG_CCR][3:0];
    assign ctx.sel_reg = rd_data;

    npp_predict u_predict (
        .ctx         (ctx),
        .instr_bytes (s1_ib_reg),
        .memory_word (s1_mem_reg),
        .dest        (pred_dest)
    );

    // Poke writes as the item moves into the result register
    assign rf_we = s1_valid_reg && advance && (s1_cmd_reg == CMD_POKE) && id_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (rf_we)
        begin
            rf_reg[s1_id_reg] <= s1_wv_reg;
        end
    end

    // Result values
    always_comb
    begin
        read_value_next = '0;
        id_valid_next   = 1'b0;
        step_dest_next  = '0;
        case (s1_cmd_reg)
            CMD_PEEK:
            begin
                id_valid_next   = id_ok;
                read_value_next = id_ok ? rd_data : '0;
            end
            CMD_POKE: id_valid_next = id_ok;
            CMD_STEP: step_dest_next = pred_dest;
            default:
            begin
                read_value_next = '0;
            end
        endcase
    end

    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            read_value_reg <= read_value_next;
            id_valid_reg   <= id_valid_next;
            step_dest_reg  <= step_dest_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign id_valid   = id_valid_reg;
    assign step_dest  = step_dest_reg;

endmodule

// ===== verif/next_pc_predictor_with_register_file_unit_tb.sv =====
// Self-checking testbench for the next-pc predictor with register file: directed and random traffic.
module next_pc_predictor_with_register_file_unit_tb;
    import npp_pkg::*;

    // Command not used by the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register ids used by name
    localparam logic [3:0] REG_R7 = 4'd7;
    localparam logic [3:0] REG_MACL = 4'd12;
    localparam logic [3:0] REG_BAD_LO = 4'd13;
    localparam logic [3:0] REG_BAD_HI = 4'd15;

    // Opcode bytes (first instruction byte) and extension bytes
    localparam logic [7:0] OP_LONG_MIN = 8'h80;
    localparam logic [7:0] OP_PREFIX = 8'h01;
    localparam logic [7:0] OP_BCC_SHORT = 8'h40;
    localparam logic [7:0] OP_BCC_SHORT_LAST = 8'h4f;
    localparam logic [7:0] OP_RTS = 8'h54;
    localparam logic [7:0] OP_BSR_SHORT = 8'h55;
    localparam logic [7:0] OP_RTE = 8'h56;
    localparam logic [7:0] OP_BCC_LONG = 8'h58;
    localparam logic [7:0] OP_JMP_REG = 8'h59;
    localparam logic [7:0] OP_JMP_ABS = 8'h5a;
    localparam logic [7:0] OP_JMP_MEM = 8'h5b;
    localparam logic [7:0] OP_BSR_LONG = 8'h5c;
    localparam logic [7:0] OP_JSR_REG = 8'h5d;
    localparam logic [7:0] OP_JSR_ABS = 8'h5e;
    localparam logic [7:0] OP_JSR_MEM = 8'h5f;
    localparam logic [7:0] OP_MOV_6A = 8'h6a;
    localparam logic [7:0] OP_MOV_6B = 8'h6b;
    localparam logic [7:0] OP_MOV_6E = 8'h6e;
    localparam logic [7:0] OP_MOV_6F = 8'h6f;
    localparam logic [7:0] OP_MOV_78 = 8'h78;
    localparam logic [7:0] OP_MOV_7A = 8'h7a;
    localparam logic [7:0] OP_MOV_7F = 8'h7f;
    localparam logic [7:0] EXT_6B = 8'h6b;
    localparam logic [7:0] EXT_6F = 8'h6f;
    localparam logic [7:0] EXT_78 = 8'h78;

    // Branch conditions, in encoding order
    typedef enum logic [3:0] {
        CC_T, CC_F, CC_HI, CC_LS, CC_CC, CC_CS, CC_NE, CC_EQ,
        CC_VC, CC_VS, CC_PL, CC_MI, CC_GE, CC_LT, CC_GT, CC_LE
    } cond_e;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1450;

    typedef struct {
        logic [31:0] rv;
        logic        vld;
        logic [31:0] dest;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_PEEK;
    logic [3:0]  reg_id = '0;
    logic [31:0] write_value = '0;
    logic [31:0] instr_bytes = '0;
    logic [31:0] memory_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_value;
    logic        id_valid;
    logic [31:0] step_dest;

    logic [31:0] shadow_regs [NUM_REGS];
    reply_t      expected_replies [$];
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned replies_checked = 0;
    int unsigned burst_left = 0;
    int unsigned n_peek = 0, n_poke = 0, n_step = 0, n_unused = 0;

    next_pc_predictor_with_register_file_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .reg_id      (reg_id),
        .write_value (write_value),
        .instr_bytes (instr_bytes),
        .memory_word (memory_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .id_valid    (id_valid),
        .step_dest   (step_dest)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
                     expected_replies.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result-side stall: the pattern follows bits 9:8 of the cycle count
    always @(posedge clk)
    begin
        case (cycle_count[9:8])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= (cycle_count[2:0] < 3'd3);
        endcase
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Evaluate a branch condition against the shadow ccr
    function automatic logic condition_met(input logic [3:0] cc);
        logic c, v, z, n;
        c = shadow_regs[REG_CCR][FLAG_C];
        v = shadow_regs[REG_CCR][FLAG_V];
        z = shadow_regs[REG_CCR][FLAG_Z];
        n = shadow_regs[REG_CCR][FLAG_N];
        case (cc)
            CC_T:  return 1'b1;
            CC_F:  return 1'b0;
            CC_HI: return !(c || z);
            CC_LS: return c || z;
            CC_CC: return !c;
            CC_CS: return c;
            CC_NE: return !z;
            CC_EQ: return z;
            CC_VC: return !v;
            CC_VS: return v;
            CC_PL: return !n;
            CC_MI: return n;
            CC_GE: return n == v;
            CC_LT: return n != v;
            CC_GT: return !z && (n == v);
            default: return z || (n != v);
        endcase
    endfunction

    // Next instruction address from the opcode bytes and the shadow registers
    function automatic logic [31:0] predict_next_pc(input logic [31:0] ib, input logic [31:0] mem);
        logic [31:0] pc, disp8, disp16;
        logic [7:0]  b0, b1, b2, b3;
        logic [3:0]  hi;
        pc = shadow_regs[REG_PC];
        {b0, b1, b2, b3} = ib;
        hi = b1[7:4];
        disp8 = {{24{b1[7]}}, b1};
        disp16 = {{16{ib[15]}}, ib[15:0]};
        if (b0 >= OP_LONG_MIN)
            return pc + 32'd2;
        if (b0 == OP_PREFIX)
        begin
            if (hi == 4'h0 || hi == 4'h4)
            begin
                if (b2 == EXT_6B)
                    return pc + (b3[1] ? 32'd8 : 32'd6);
                if (b2 == EXT_6F)
                    return pc + 32'd6;
                if (b2 == EXT_78)
                    return pc + 32'd10;
                return pc + 32'd4;
            end
            if (hi == 4'h8 || hi == 4'ha)
                return pc + 32'd2;
            return pc + 32'd4;
        end
        if (b0 < OP_BCC_SHORT)
            return pc + 32'd2;
        if (b0 <= OP_BCC_SHORT_LAST)
            return condition_met(b0[3:0]) ? pc + 32'd2 + disp8 : pc + 32'd2;
        case (b0)
            OP_RTS, OP_RTE, OP_JMP_MEM, OP_JSR_MEM: return mem & ADDR_MASK;
            OP_BSR_SHORT: return pc + 32'd2 + disp8;
            OP_BCC_LONG:  return condition_met(hi) ? pc + 32'd4 + disp16 : pc + 32'd4;
            OP_JMP_REG, OP_JSR_REG: return shadow_regs[hi[2:0]];
            OP_JMP_ABS, OP_JSR_ABS: return ib & ADDR_MASK;
            OP_BSR_LONG:  return pc + 32'd4 + disp16;
            OP_MOV_6A, OP_MOV_6B:
            begin
                if (hi == 4'h1 || hi == 4'h2 || hi == 4'ha)
                    return pc + 32'd6;
                if (hi == 4'h3)
                    return pc + 32'd8;
                return pc + 32'd4;
            end
            OP_MOV_6E, OP_MOV_6F: return pc + 32'd4;
            OP_MOV_78: return pc + 32'd8;
            OP_MOV_7A: return pc + 32'd6;
            default:
            begin
                // the remaining opcodes above 0x78 are four bytes long
                if (b0 > OP_MOV_78)
                    return pc + 32'd4;
                return pc + 32'd2;
            end
        endcase
    endfunction

    // Apply one command to the shadow registers and form its reply
    function automatic reply_t model_command(input logic [1:0] c, input logic [3:0] id,
                                             input logic [31:0] wv, input logic [31:0] ib,
                                             input logic [31:0] mem);
        reply_t r;
        r.rv = '0;
        r.vld = 1'b0;
        r.dest = '0;
        case (c)
            CMD_PEEK:
            begin
                if (id < NUM_REGS)
                begin
                    r.rv = shadow_regs[id];
                    r.vld = 1'b1;
                end
            end
            CMD_POKE:
            begin
                if (id < NUM_REGS)
                begin
                    shadow_regs[id] = wv;
                    r.vld = 1'b1;
                end
            end
            CMD_STEP: r.dest = predict_next_pc(ib, mem);
            default: ;
        endcase
        return r;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = expected_replies.pop_front();
                replies_checked++;
                if (read_value !== want.rv)
                    report_mismatch($sformatf("read_value %h, expected %h", read_value, want.rv));
                if (id_valid !== want.vld)
                    report_mismatch($sformatf("id_valid %b, expected %b", id_valid, want.vld));
                if (step_dest !== want.dest)
                    report_mismatch($sformatf("step_dest %h, expected %h", step_dest, want.dest));
            end
        end
    end

    // One input transfer, with a random gap at the start of each burst
    task automatic send_item(input logic [1:0] c, input logic [3:0] id, input logic [31:0] wv,
                             input logic [31:0] ib, input logic [31:0] mem);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        reg_id <= id;
        write_value <= wv;
        instr_bytes <= ib;
        memory_word <= mem;
        do
            @(posedge clk);
        while (in_stall);
        expected_replies.push_back(model_command(c, id, wv, ib, mem));
        case (c)
            CMD_PEEK: n_peek++;
            CMD_POKE: n_poke++;
            CMD_STEP: n_step++;
            default:  n_unused++;
        endcase
    endtask

    // Hold the sender off until every reply is back
    task automatic drain_replies();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // Peek and poke at the edges of the id range, and the unused command
    task automatic test_register_access();
        send_item(CMD_POKE, '0, 32'hffff_ffff, '0, '0);
        send_item(CMD_POKE, REG_MACL, 32'h0, '0, '0);
        send_item(CMD_POKE, REG_BAD_LO, 32'h1234_5678, '0, '0);
        send_item(CMD_PEEK, '0, '0, '0, '0);
        send_item(CMD_PEEK, REG_MACL, '0, '0, '0);
        send_item(CMD_PEEK, REG_BAD_HI, '0, '0, '0);
        send_item(CMD_UNUSED, REG_BAD_HI, '1, '1, '1);
    endtask

    // A directed sample of the step rules, pc near the top so that sums wrap
    task automatic test_step_decode();
        send_item(CMD_POKE, REG_PC, 32'hffff_fffe, '0, '0);
        send_item(CMD_POKE, REG_CCR, 32'h0000_0008, '0, '0);
        send_item(CMD_STEP, '0, '0, {OP_LONG_MIN, 24'h0}, '0);
        send_item(CMD_STEP, '0, '0, {OP_PREFIX, 8'h00, EXT_6B, 8'h02}, '0);
        send_item(CMD_STEP, '0, '0, {OP_PREFIX, 8'h40, EXT_78, 8'h00}, '0);
        send_item(CMD_STEP, '0, '0, {OP_BCC_SHORT[7:4], CC_LT, 8'hfe, 16'h0}, '0);
        send_item(CMD_STEP, '0, '0, {OP_BCC_SHORT[7:4], CC_GE, 8'h7f, 16'h0}, '0);
        send_item(CMD_STEP, '0, '0, {OP_BCC_LONG, CC_LE, 4'h0, 16'h8000}, '0);
        send_item(CMD_STEP, '0, '0, {OP_BSR_LONG, 8'h00, 16'h7fff}, '0);
        send_item(CMD_STEP, '0, '0, {OP_JMP_REG, 8'hf0, 16'h0}, '0);
        send_item(CMD_STEP, '0, '0, {OP_JMP_ABS, 24'hff_ffff}, '0);
        send_item(CMD_STEP, '0, '0, {OP_RTS, 24'h0}, 32'hffff_ffff);
        send_item(CMD_STEP, '0, '0, {OP_MOV_6A, 8'h30, 16'h0}, '0);
        send_item(CMD_STEP, '0, '0, {OP_MOV_7F, 24'h0}, '0);
        send_item(CMD_STEP, '0, '0, 32'h0, '0);
    endtask

    // Random mix weighted towards steps over well-formed opcodes
    task automatic test_random_traffic();
        logic [7:0]  flow_ops [10];
        logic [7:0]  b0, b1, b2, b3;
        logic [3:0]  id;
        logic [1:0]  c;
        int unsigned pick;
        flow_ops = '{OP_RTS, OP_BSR_SHORT, OP_RTE, OP_JMP_MEM, OP_BSR_LONG, OP_JSR_MEM,
                     OP_JMP_REG, OP_JSR_REG, OP_JMP_ABS, OP_JSR_ABS};
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i != 0 && i % 480 == 0)
                drain_replies();
            pick = $urandom_range(0, 99);
            id = 4'($urandom_range(0, 15));
            {b0, b1, b2, b3} = $urandom();
            if (pick < 12)
            begin
                c = CMD_POKE;
                // pc and ccr steer the prediction, so write them often
                if ($urandom_range(0, 2) == 0)
                    id = $urandom_range(0, 1) ? REG_PC : REG_CCR;
            end
            else if (pick < 24)
                c = CMD_PEEK;
            else if (pick < 28)
                c = CMD_UNUSED;
            else
            begin
                c = CMD_STEP;
                case ($urandom_range(0, 9))
                    0, 1: ;
                    2:
                    begin
                        b0 = OP_PREFIX;
                        case ($urandom_range(0, 3))
                            0: b2 = EXT_6B;
                            1: b2 = EXT_6F;
                            2: b2 = EXT_78;
                            default: ;
                        endcase
                    end
                    3: b0 = {OP_BCC_SHORT[7:4], b0[3:0]};
                    4: b0 = OP_BCC_LONG;
                    5, 6: b0 = flow_ops[$urandom_range(0, 9)];
                    7: b0 = $urandom_range(0, 1) ? OP_MOV_6A : OP_MOV_6B;
                    8: b0 = 8'($urandom_range(OP_MOV_6E, OP_MOV_7F));
                    default: b0 = 8'($urandom_range(0, 8'h3f));
                endcase
            end
            send_item(c, id, $urandom(), {b0, b1, b2, b3}, $urandom());
        end
    endtask

    initial
    begin
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_step_decode();
        test_random_traffic();

        // Wind down: every reply back, then a few spare cycles for strays
        drain_replies();
        repeat (8) @(posedge clk);

        $display("Sent %0d peeks, %0d pokes, %0d steps and %0d unused commands", n_peek, n_poke,
                 n_step, n_unused);
        $display("Checked %0d replies under random sender gaps and result stalls, %0d errors",
                 replies_checked, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
